FILE: design/sitrt_pkg.sv
// Package for the signed integer to radix text core.
// Holds the shared constants, the job flag struct and the digit character function.
// No dependencies.
package sitrt_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_MAX_DIGITS  = 32;

	// Radix register.
	localparam int                RADIX_W     = 6;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	// Characters.
	localparam int               CHAR_W     = 8;
	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
	localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
	localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
	// 'a' minus ten, so that a digit of ten or more maps onto the letters.
	localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'h57;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

	// Quotient bits resolved by the divider in one cycle.
	localparam int STEP_BITS = 8;

	// Depth of the job queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Per-job classification made at the front.
	typedef struct packed {
		logic               negative;
		logic               radix_ok;
		logic [RADIX_W-1:0] radix;
	} job_flags_t;

	localparam int FLAGS_W = $bits(job_flags_t);

	// Lower-case character of one digit value (0 to 35).
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] digit);
		logic [CHAR_W-1:0] ext;
		ext = CHAR_W'(digit);
		if (digit < DEC_DIGITS) begin
			digit_char = ZERO_CHAR + ext;
		end else begin
			digit_char = ALPHA_BASE + ext;
		end
	endfunction

endpackage

FILE: design/sitrt_channels.sv
// Handshake channel interfaces of the signed integer to radix text core.
// Uses sitrt_pkg for the default value width and the character width.
interface sitrt_number_if #(parameter int VALUE_WIDTH = sitrt_pkg::DEF_VALUE_WIDTH);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface sitrt_text_if;
	logic                          valid;
	logic                          ready;
	logic [sitrt_pkg::CHAR_W-1:0]  text_char;
	logic                          is_last;

	modport source (output valid, output text_char, output is_last, input ready);
	modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

FILE: design/signed_integer_to_radix_text_core.sv
// Signed integer to radix text: turns each signed number into lower-case ASCII
// text in the base held in the radix register (2 to 36, reset 10): an optional
// minus sign, the digits most significant first, then a NUL marked is_last. A
// radix outside 2 to 36 gives only the NUL. A front part takes numbers into a
// two-entry job queue; a back part works one job at a time. Per number the back
// part takes the job, finds the digits one after another in its shared divider
// (eight quotient bits per cycle), passes a settle state before the digit store
// is read, and then sends the characters, one per cycle while the receiver is
// ready. Depends on sitrt_pkg, the channel interfaces and submodules.
module signed_integer_to_radix_text_core #(
	parameter int VALUE_WIDTH = sitrt_pkg::DEF_VALUE_WIDTH,
	parameter int MAX_DIGITS  = sitrt_pkg::DEF_MAX_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sitrt_number_if.sink                  number_ch,
	sitrt_text_if.source                  text_ch,
	input  logic                          radix_we,
	input  logic [sitrt_pkg::RADIX_W-1:0] radix_wdata
);
	import sitrt_pkg::*;

	localparam int JOB_W = VALUE_WIDTH + FLAGS_W;

	logic                   job_push;
	logic [VALUE_WIDTH-1:0] push_mag;
	job_flags_t             push_flags;
	logic                   queue_full;
	logic                   job_pop;
	logic                   job_valid;
	logic [JOB_W-1:0]       pop_data;
	logic [VALUE_WIDTH-1:0] pop_mag;
	job_flags_t             pop_flags;

	// Accept and classify.
	sitrt_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_ch   (number_ch),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.queue_full  (queue_full),
		.job_push    (job_push),
		.job_mag     (push_mag),
		.job_flags   (push_flags)
	);

	// Job queue between the two parts.
	sitrt_queue #(
		.DATA_W (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data ({push_mag, push_flags}),
		.full      (queue_full),
		.pop       (job_pop),
		.pop_data  (pop_data),
		.not_empty (job_valid)
	);

	assign pop_mag   = pop_data[JOB_W-1:FLAGS_W];
	assign pop_flags = pop_data[FLAGS_W-1:0];

	// Divide and send the text.
	sitrt_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_mag   (pop_mag),
		.job_flags (pop_flags),
		.job_pop   (job_pop),
		.text_ch   (text_ch)
	);

endmodule

FILE: design/sitrt_queue.sv
// Short job queue between the front and back parts.
// Uses sitrt_pkg for the queue depth.
module sitrt_queue #(
	parameter int DATA_W = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              not_empty
);
	import sitrt_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = entry_q[rd_ptr_q];

	// Storage of the queued jobs.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap over the queue depth; the fill count follows pushes and pops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: design/sitrt_front.sv
// Front part: holds the radix register, accepts numbers and classifies them.
// Uses sitrt_pkg and the sitrt_number_if channel; feeds the job queue.
module sitrt_front #(
	parameter int VALUE_WIDTH = sitrt_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sitrt_number_if.sink                  number_ch,
	input  logic                          radix_we,
	input  logic [sitrt_pkg::RADIX_W-1:0] radix_wdata,
	input  logic                          queue_full,
	output logic                          job_push,
	output logic [VALUE_WIDTH-1:0]        job_mag,
	output sitrt_pkg::job_flags_t         job_flags
);
	import sitrt_pkg::*;

	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] raw;

	// Radix register; the user must write it only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	// A number is taken whenever the queue has room.
	assign number_ch.ready = !queue_full;
	assign job_push        = number_ch.valid && !queue_full;

	// Split the value into sign and unsigned magnitude; the most negative
	// value keeps its full magnitude because the result is read unsigned.
	assign raw                = VALUE_WIDTH'(number_ch.number);
	assign job_flags.negative = raw[VALUE_WIDTH-1];
	assign job_mag            = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
	assign job_flags.radix_ok = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
	assign job_flags.radix    = radix_q;

endmodule

FILE: design/sitrt_back.sv
// Back part: divides the magnitude by the radix a digit at a time, stores the
// digits and then sends the text. Uses sitrt_pkg and the sitrt_text_if channel.
module sitrt_back #(
	parameter int VALUE_WIDTH = sitrt_pkg::DEF_VALUE_WIDTH,
	parameter int MAX_DIGITS  = sitrt_pkg::DEF_MAX_DIGITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  logic [VALUE_WIDTH-1:0] job_mag,
	input  sitrt_pkg::job_flags_t  job_flags,
	output logic                   job_pop,
	sitrt_text_if.source           text_ch
);
	import sitrt_pkg::*;

	// Dividend padded to whole divider steps.
	localparam int PADW   = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int NSTEPS = PADW / STEP_BITS;
	localparam int SW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
	localparam int AW     = $clog2(MAX_DIGITS);
	localparam int CW     = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETTLE,
		ST_SIGN,
		ST_DIGITS,
		ST_TERM
	} state_t;

	state_t             state_q;
	logic [PADW-1:0]    div_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic               negative_q;
	logic [SW-1:0]      step_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      rd_addr_q;
	logic [AW-1:0]      rd_addr_next;
	logic [CHAR_W-1:0]  rdata_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	logic [CHAR_W-1:0]  digit_mem [MAX_DIGITS];

	logic [PADW-1:0]    quo_next;
	logic [RADIX_W-1:0] rem_next;
	logic [CW-1:0]      count_inc;
	logic               last_step;
	logic               more_digits;
	logic               can_load;
	logic               out_load;
	logic               mem_we;

	// Restoring division, STEP_BITS quotient bits per cycle; the quotient
	// bits shift into the bottom of the dividend register.
	always_comb begin
		logic [RADIX_W:0]   trial;
		logic [RADIX_W-1:0] r;
		logic [PADW-1:0]    d;
		r = rem_q;
		d = div_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {r, d[PADW-1]};
			d     = {d[PADW-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				r    = RADIX_W'(trial - {1'b0, radix_q});
				d[0] = 1'b1;
			end else begin
				r = trial[RADIX_W-1:0];
			end
		end
		quo_next = d;
		rem_next = r;
	end

	assign last_step   = (state_q == ST_DIV) && (step_q == SW'(NSTEPS - 1));
	assign count_inc   = count_q + CW'(1);
	assign more_digits = (quo_next != '0) && (count_inc < CW'(MAX_DIGITS));
	assign can_load    = !out_valid_q || text_ch.ready;
	assign out_load    = can_load && ((state_q == ST_SIGN) || (state_q == ST_DIGITS) ||
		(state_q == ST_TERM));
	assign mem_we      = last_step;
	assign job_pop     = (state_q == ST_IDLE) && job_valid;

	// Read address for the next cycle; the digits go out from the top down.
	always_comb begin
		rd_addr_next = rd_addr_q;
		if (last_step && !more_digits) begin
			rd_addr_next = count_q[AW-1:0];
		end else if (state_q == ST_DIGITS && can_load && rd_addr_q != '0) begin
			rd_addr_next = rd_addr_q - AW'(1);
		end
	end

	// Digit store: written once per digit, read with a registered port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[count_q[AW-1:0]] <= digit_char(rem_next);
		end
		rdata_q <= digit_mem[rd_addr_next];
	end

	// Sequencer with the divider registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_q       <= '0;
			rem_q       <= '0;
			radix_q     <= RADIX_RESET;
			negative_q  <= 1'b0;
			step_q      <= '0;
			count_q     <= '0;
			rd_addr_q   <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= NUL_CHAR;
			out_last_q  <= 1'b0;
		end else begin
			rd_addr_q <= rd_addr_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (text_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						div_q      <= PADW'(job_mag);
						rem_q      <= '0;
						radix_q    <= job_flags.radix;
						negative_q <= job_flags.negative;
						step_q     <= '0;
						count_q    <= '0;
						state_q    <= job_flags.radix_ok ? ST_DIV : ST_TERM;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						count_q <= count_inc;
						step_q  <= '0;
						rem_q   <= '0;
						div_q   <= quo_next;
						if (!more_digits) begin
							state_q <= ST_SETTLE;
						end
					end else begin
						step_q <= step_q + SW'(1);
						div_q  <= quo_next;
						rem_q  <= rem_next;
					end
				end
				ST_SETTLE: begin
					// The last digit written is readable from this cycle on.
					state_q <= negative_q ? ST_SIGN : ST_DIGITS;
				end
				ST_SIGN: begin
					if (can_load) begin
						out_char_q  <= MINUS_CHAR;
						out_last_q  <= 1'b0;
						state_q     <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (can_load) begin
						out_char_q  <= rdata_q;
						out_last_q  <= 1'b0;
						if (rd_addr_q == '0) begin
							state_q <= ST_TERM;
						end
					end
				end
				ST_TERM: begin
					if (can_load) begin
						out_char_q  <= NUL_CHAR;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign text_ch.valid     = out_valid_q;
	assign text_ch.text_char = out_char_q;
	assign text_ch.is_last   = out_last_q;

endmodule

FILE: tb/signed_integer_to_radix_text_core_tb.sv
// Testbench for signed_integer_to_radix_text_core: it drives signed numbers in many radix
// settings, predicts the text of each one and checks every character and its last flag.
// Depends on sitrt_pkg, the channel interfaces in sitrt_channels.sv and the core itself.
module signed_integer_to_radix_text_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sitrt_pkg::*;

	localparam int VW = 32;
	localparam int DIGIT_SLOTS = 32;
	localparam int IDLE_PERCENT = 16;
	localparam int HOLD_START = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int CALM_FIRST = 250;
	localparam int CALM_LAST = 330;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PRINT_LIMIT = 40;

	// One expected character of the text.
	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		logic              last;
	} text_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic radix_we;
	logic [RADIX_W-1:0] radix_wdata;

	sitrt_number_if #(.VALUE_WIDTH(VW)) number_ch ();
	sitrt_text_if text_ch ();

	signed_integer_to_radix_text_core #(
		.VALUE_WIDTH(VW),
		.MAX_DIGITS (DIGIT_SLOTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.number_ch  (number_ch),
		.text_ch    (text_ch),
		.radix_we   (radix_we),
		.radix_wdata(radix_wdata)
	);

	always #2 clk = ~clk;

	// Numbers waiting to be offered, and characters waiting to come out.
	logic [VW-1:0] pending_numbers [$];
	text_word_t text_expected [$];

	// Shadow of the radix register and of the conversion state.
	logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
	logic [VW-1:0] quotient_shadow;
	logic [CHAR_W-1:0] digit_shadow [DIGIT_SLOTS];
	int unsigned digit_total;
	logic sign_shadow;

	int unsigned mismatches = 0;
	int unsigned numbers_taken = 0;
	int unsigned chars_checked = 0;
	int unsigned settings_used = 1;
	int unsigned cycle_count = 0;
	int unsigned hold_left = 0;
	logic hold_done = 1'b0;
	logic number_word_taken = 1'b0;
	logic calm_window;

	assign calm_window = (numbers_taken >= CALM_FIRST) && (numbers_taken < CALM_LAST);

	task automatic log_mismatch(input string what);
		if (mismatches < PRINT_LIMIT) begin
			$display("[%0t] MISMATCH: %s", $realtime, what);
		end
		mismatches++;
	endtask

	// Works out the characters one number turns into and queues them.
	function automatic void predict_text(input logic [VW-1:0] value);
		logic [VW-1:0] rem;
		if (radix_shadow < RADIX_MIN || radix_shadow > RADIX_MAX) begin
			// A radix out of range yields the terminator alone and keeps the state.
			text_expected.push_back({NUL_CHAR, 1'b1});
			return;
		end
		sign_shadow = value[VW-1];
		quotient_shadow = sign_shadow ? (~value + 1'b1) : value;
		digit_total = 0;
		do begin
			rem = quotient_shadow % VW'(radix_shadow);
			quotient_shadow = quotient_shadow / VW'(radix_shadow);
			if (rem < 10) begin
				digit_shadow[digit_total] = 8'h30 + CHAR_W'(rem);
			end else begin
				digit_shadow[digit_total] = 8'h61 + CHAR_W'(rem - 10);
			end
			digit_total++;
		end while (quotient_shadow != 0 && digit_total < DIGIT_SLOTS);
		quotient_shadow = '0;
		if (sign_shadow) begin
			text_expected.push_back({MINUS_CHAR, 1'b0});
		end
		for (int i = digit_total; i > 0; i--) begin
			text_expected.push_back({digit_shadow[i-1], 1'b0});
		end
		text_expected.push_back({NUL_CHAR, 1'b1});
	endfunction

	// Picks a number: full random, short texts, near a power of the base, or an extreme value.
	function automatic logic [VW-1:0] pick_number(input logic [RADIX_W-1:0] base);
		logic [VW-1:0] p;
		int unsigned sel;
		int unsigned k;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			return $urandom;
		end
		if (sel < 65) begin
			p = $urandom_range(0, 200);
			return $urandom_range(0, 1) ? -p : p;
		end
		if (sel < 88 && base >= RADIX_MIN && base <= RADIX_MAX) begin
			p = 1;
			k = $urandom_range(1, 31);
			repeat (k) begin
				if (p <= 32'hFFFF_FFFF / VW'(base)) begin
					p = p * VW'(base);
				end
			end
			p = p + $urandom_range(0, 2) - 1;
			return $urandom_range(0, 1) ? -p : p;
		end
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic queue_random(input logic [RADIX_W-1:0] base, input int count);
		repeat (count) pending_numbers.push_back(pick_number(base));
	endtask

	// Waits until every queued number is taken and every expected character is out.
	task automatic drain_text();
		while (pending_numbers.size() != 0 || number_ch.valid) @(posedge clk);
		while (text_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] base);
		drain_text();
		@(negedge clk);
		radix_we <= 1'b1;
		radix_wdata <= base;
		@(negedge clk);
		radix_we <= 1'b0;
		settings_used++;
	endtask

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d characters still expected",
				cycle_count, text_expected.size());
			$display("signed_integer_to_radix_text_core verification failed");
			$finish;
		end
	end

	// Sender: holds a word until it is taken, then offers the next one or idles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!number_ch.valid || number_word_taken) begin
				if (pending_numbers.size() != 0 &&
					(calm_window || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
					number_ch.valid <= 1'b1;
					number_ch.number <= pending_numbers.pop_front();
				end else begin
					number_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, and one long hold-off so that the core backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			text_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			text_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && numbers_taken >= HOLD_START) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			text_ch.ready <= 1'b0;
		end else begin
			text_ch.ready <= calm_window || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Watches both channels: checks each character, then predicts each new number.
	always @(posedge clk) begin : watch_ports
		text_word_t want;
		if (arst_n) begin
			if (radix_we) begin
				radix_shadow <= radix_wdata;
			end
			number_word_taken <= number_ch.valid && number_ch.ready;
			if (text_ch.valid && text_ch.ready) begin
				chars_checked++;
				if (text_expected.size() == 0) begin
					log_mismatch($sformatf("unexpected character 0x%02h last %0b",
						text_ch.text_char, text_ch.is_last));
				end else begin
					want = text_expected.pop_front();
					if (text_ch.text_char !== want.glyph) begin
						log_mismatch($sformatf("character 0x%02h, expected 0x%02h",
							text_ch.text_char, want.glyph));
					end
					if (text_ch.is_last !== want.last) begin
						log_mismatch($sformatf("is_last %0b, expected %0b on character 0x%02h",
							text_ch.is_last, want.last, want.glyph));
					end
				end
			end
			if (number_ch.valid && number_ch.ready) begin
				numbers_taken++;
				predict_text(number_ch.number);
			end
		end
	end

	// Stimulus: reset, directed numbers, then random phases over many radix settings.
	initial begin
		logic [RADIX_W-1:0] base;
		arst_n = 1'b0;
		radix_we = 1'b0;
		radix_wdata = '0;
		number_ch.valid = 1'b0;
		number_ch.number = '0;
		text_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Decimal after reset: zero, unit values, both extremes and long texts.
		pending_numbers.push_back(32'd0);
		pending_numbers.push_back(32'd1);
		pending_numbers.push_back(-32'sd1);
		pending_numbers.push_back(32'd9);
		pending_numbers.push_back(32'd10);
		pending_numbers.push_back(-32'sd10);
		pending_numbers.push_back(32'h7FFF_FFFF);
		pending_numbers.push_back(32'h8000_0000);
		pending_numbers.push_back(32'd123456789);
		pending_numbers.push_back(-32'sd987654321);
		queue_random(RADIX_RESET, 40);

		// Binary gives the longest texts, the most negative value among them.
		write_radix(RADIX_MIN);
		pending_numbers.push_back(32'h8000_0000);
		pending_numbers.push_back(32'h7FFF_FFFF);
		pending_numbers.push_back(-32'sd1);
		queue_random(RADIX_MIN, 30);

		// Base 36 reaches the last letter.
		write_radix(RADIX_MAX);
		pending_numbers.push_back(32'h8000_0000);
		pending_numbers.push_back(32'h7FFF_FFFF);
		pending_numbers.push_back(32'd35);
		pending_numbers.push_back(32'd36);
		pending_numbers.push_back(-32'sd36);
		queue_random(RADIX_MAX, 30);

		// Radix values out of range give the terminator alone.
		write_radix(6'd0);
		pending_numbers.push_back(32'd0);
		pending_numbers.push_back(32'h8000_0000);
		queue_random(6'd0, 6);
		write_radix(6'd63);
		queue_random(6'd63, 6);
		write_radix(6'd1);
		queue_random(6'd1, 4);
		write_radix(6'd37);
		queue_random(6'd37, 4);

		// Random bases in range.
		repeat (8) begin
			base = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
			write_radix(base);
			queue_random(base, 30);
		end

		// Back to decimal to finish.
		write_radix(RADIX_RESET);
		queue_random(RADIX_RESET, 30);

		drain_text();
		repeat (20) @(posedge clk);
		$display("Converted %0d numbers into %0d characters over %0d radix settings,",
			numbers_taken, chars_checked, settings_used);
		$display("with random stalls on both sides and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0 && text_expected.size() == 0) begin
			$display("signed_integer_to_radix_text_core verification clean");
		end else begin
			$display("signed_integer_to_radix_text_core verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
design/sitrt_pkg.sv
design/sitrt_channels.sv
design/sitrt_queue.sv
design/sitrt_front.sv
design/sitrt_back.sv
design/signed_integer_to_radix_text_core.sv
tb/signed_integer_to_radix_text_core_tb.sv
